[rtl/ptre_pkg.sv]
// ============================================================================
// ptre_pkg - shared types and constants for the portal table root election
// Entry layout, item structs, opcode and result codes, and the control groups
// that pass between the sequencer, the table memory and the compare unit.
// ============================================================================
`default_nettype none

package ptre_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int RES_MAX       = 32;
   localparam int NRES_W        = $clog2(RES_MAX + 1);

   // field widths
   localparam int MAC_W = 48;
   localparam int SEQ_W = 32;
   localparam int TMR_W = 8;
   localparam int CNT_W = 6;

   localparam logic [MAC_W-1:0] MAC_ALL_ONES  = '1;
   localparam logic [TMR_W-1:0] TIMEOUT_RESET = TMR_W'(10);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WANT_ROOT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = CSR_IDX_W'(2);

   typedef enum logic [1:0] {
      OP_ANNOUNCE = 2'd0,
      OP_TICK     = 2'd1,
      OP_DECIDE   = 2'd2,
      OP_CLEAR    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_IGNORED   = 3'd1,
      KIND_EXPIRED   = 3'd2,
      KIND_TICK_NONE = 3'd3,
      KIND_DECIDED   = 3'd4,
      KIND_SKIPPED   = 3'd5
   } kind_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [MAC_W-1:0]   orig_mac;
      logic [SEQ_W-1:0]   seq_number;
      logic               wants_root_bit;
      logic               path_fresh;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [MAC_W-1:0]   mac_out;
      logic               is_root_out;
      logic [CNT_W-1:0]   willing_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [MAC_W-1:0]   own_mac;
      logic               want_root;
      logic [TMR_W-1:0]   timeout;
   } cfg_type;

   typedef struct packed {
      logic [MAC_W-1:0]   addr;
      logic [SEQ_W-1:0]   seq;
      logic               willing;
      logic [TMR_W-1:0]   timer;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0]   rd_idx;
      logic [IDX_W-1:0]   wr_idx;
      logic               we_all;
      logic               we_timer;
   } tbl_ctl_type;

   typedef struct packed {
      logic               lt;
      logic               eq;
   } cmp_res_type;

endpackage

`default_nettype wire

[rtl/ptre_cmp.sv]
// ============================================================================
// ptre_cmp - shared 48-bit address comparator
// Single magnitude/equality compare for the check, scan and decide states.
// ============================================================================
`default_nettype none

module ptre_cmp (
   input  wire logic [ptre_pkg::MAC_W-1:0] cmp_a,
   input  wire logic [ptre_pkg::MAC_W-1:0] cmp_b,
   output ptre_pkg::cmp_res_type           cmp_res
);

   // unsigned compare, a against b
   always_comb begin
      cmp_res.lt = (cmp_a < cmp_b);
      cmp_res.eq = (cmp_a == cmp_b);
   end

endmodule

`default_nettype wire

[rtl/ptre_table.sv]
// ============================================================================
// ptre_table - portal entry storage
// One write port (full entry or timer only) and one registered read port.
// Contents are undefined until written; validity is tracked by the sequencer.
// ============================================================================
`default_nettype none

module ptre_table (
   input  wire logic                  clock,
   input  ptre_pkg::tbl_ctl_type      tbl_ctl,
   input  ptre_pkg::entry_type        wr_entry,
   output ptre_pkg::entry_type        rd_entry
);

   logic [ptre_pkg::MAC_W-1:0] addr_mem [ptre_pkg::TABLE_ENTRIES];
   logic [ptre_pkg::SEQ_W-1:0] seq_mem  [ptre_pkg::TABLE_ENTRIES];
   logic                       will_mem [ptre_pkg::TABLE_ENTRIES];
   logic [ptre_pkg::TMR_W-1:0] tmr_mem  [ptre_pkg::TABLE_ENTRIES];

   ptre_pkg::entry_type rd_entry_ff;

   // write port
   always_ff @(posedge clock) begin
      if (tbl_ctl.we_all) begin
         addr_mem[tbl_ctl.wr_idx] <= wr_entry.addr;
         seq_mem[tbl_ctl.wr_idx]  <= wr_entry.seq;
         will_mem[tbl_ctl.wr_idx] <= wr_entry.willing;
      end
      if (tbl_ctl.we_all || tbl_ctl.we_timer) begin
         tmr_mem[tbl_ctl.wr_idx] <= wr_entry.timer;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_entry_ff.addr    <= addr_mem[tbl_ctl.rd_idx];
      rd_entry_ff.seq     <= seq_mem[tbl_ctl.rd_idx];
      rd_entry_ff.willing <= will_mem[tbl_ctl.rd_idx];
      rd_entry_ff.timer   <= tmr_mem[tbl_ctl.rd_idx];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

[rtl/ptre_seq.sv]
// ============================================================================
// ptre_seq - operation sequencer
// Walks the table one entry per cycle for announce, tick and decide (unless a
// tick expiry waits for the output register), holds the valid bits, the
// decision flags, one pending result and the output register. Tick expiries
// are held one deep so the final one can carry last.
`default_nettype none

module ptre_seq (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  ptre_pkg::cfg_type                cfg,
   // item input
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  ptre_pkg::req_type                req_data,
   // result output
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output ptre_pkg::rsp_type                rsp_data,
   // table memory
   output ptre_pkg::tbl_ctl_type            tbl_ctl,
   output ptre_pkg::entry_type              wr_entry,
   input  ptre_pkg::entry_type              rd_entry,
   // shared comparator
   output logic [ptre_pkg::MAC_W-1:0]       cmp_a,
   output logic [ptre_pkg::MAC_W-1:0]       cmp_b,
   input  ptre_pkg::cmp_res_type            cmp_res
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_WRITE  = 6'b001000,
      ST_DECIDE = 6'b010000,
      ST_FLUSH  = 6'b100000
   } state_type;

   // control state
   state_type                            state_ff, state_in;
   logic [ptre_pkg::TABLE_ENTRIES-1:0]   valid_ff, valid_in;
   logic                                 decided_ff, decided_in;
   logic                                 is_root_ff, is_root_in;
   logic                                 pend_valid_ff, pend_valid_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 hit_found_ff, hit_found_in;
   logic                                 free_found_ff, free_found_in;

   // working data
   ptre_pkg::req_type                    req_ff, req_in;
   logic [ptre_pkg::IDX_W-1:0]           idx_ff, idx_in;
   logic [ptre_pkg::IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic [ptre_pkg::IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic [ptre_pkg::MAC_W-1:0]           root_ff, root_in;
   logic [ptre_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [ptre_pkg::NRES_W-1:0]          nres_ff, nres_in;
   ptre_pkg::kind_type                   pend_kind_ff, pend_kind_in;
   logic [ptre_pkg::MAC_W-1:0]           pend_mac_ff, pend_mac_in;
   logic [ptre_pkg::CNT_W-1:0]           pend_cnt_ff, pend_cnt_in;
   ptre_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic                                 ent_vld;
   logic                                 last_idx;
   logic                                 out_free;
   logic [ptre_pkg::TMR_W-1:0]           tmr_dec;
   logic                                 expire;
   logic                                 room;
   logic                                 scan_stall;
   logic                                 slot_ok;
   logic [ptre_pkg::IDX_W-1:0]           slot_idx;

   // per-entry status of the entry being scanned
   assign ent_vld   = valid_ff[idx_ff];
   assign last_idx  = (idx_ff == ptre_pkg::IDX_W'(ptre_pkg::TABLE_ENTRIES - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tmr_dec   = rd_entry.timer - 1'b1;
   assign expire    = (req_ff.opcode == ptre_pkg::OP_TICK) && ent_vld && (tmr_dec == '0);
   assign room      = (nres_ff < ptre_pkg::NRES_W'(ptre_pkg::RES_MAX));
   // a second expiry cannot be parked until the output register frees up
   assign scan_stall = (state_ff == ST_SCAN) && expire && room && pend_valid_ff && !out_free;
   assign slot_ok   = hit_found_ff || free_found_ff;
   assign slot_idx  = hit_found_ff ? hit_idx_ff : free_idx_ff;

   // comparator operand select
   always_comb begin
      case (state_ff)
         ST_CHECK: begin
            cmp_a = req_ff.orig_mac;
            cmp_b = cfg.own_mac;
         end
         ST_DECIDE: begin
            cmp_a = cfg.own_mac;
            cmp_b = root_ff;
         end
         default: begin
            cmp_a = rd_entry.addr;
            cmp_b = (req_ff.opcode == ptre_pkg::OP_ANNOUNCE) ? req_ff.orig_mac : root_ff;
         end
      endcase
   end

   // table port control
   always_comb begin
      tbl_ctl.rd_idx   = '0;
      if (state_ff == ST_SCAN) begin
         tbl_ctl.rd_idx = scan_stall ? idx_ff : idx_ff + 1'b1;
      end
      tbl_ctl.wr_idx   = (state_ff == ST_WRITE) ? slot_idx : idx_ff;
      tbl_ctl.we_all   = (state_ff == ST_WRITE) && slot_ok;
      tbl_ctl.we_timer = (state_ff == ST_SCAN) && (req_ff.opcode == ptre_pkg::OP_TICK) &&
                         ent_vld && !scan_stall;
      wr_entry.addr    = req_ff.orig_mac;
      wr_entry.seq     = req_ff.seq_number;
      wr_entry.willing = req_ff.wants_root_bit;
      wr_entry.timer   = (state_ff == ST_WRITE) ? cfg.timeout : tmr_dec;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      decided_in    = decided_ff;
      is_root_in    = is_root_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      root_in       = root_ff;
      cnt_in        = cnt_ff;
      nres_in       = nres_ff;
      pend_kind_in  = pend_kind_ff;
      pend_mac_in   = pend_mac_ff;
      pend_cnt_in   = pend_cnt_ff;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               idx_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               root_in       = ptre_pkg::MAC_ALL_ONES;
               cnt_in        = '0;
               nres_in       = '0;
               pend_valid_in = 1'b0;
               pend_mac_in   = '0;
               pend_cnt_in   = '0;
               case (req_data.opcode)
                  ptre_pkg::OP_ANNOUNCE: state_in = ST_CHECK;
                  ptre_pkg::OP_TICK:     state_in = ST_SCAN;
                  ptre_pkg::OP_DECIDE: begin
                     if (decided_ff) begin
                        pend_valid_in = 1'b1;
                        pend_kind_in  = ptre_pkg::KIND_SKIPPED;
                        state_in      = ST_FLUSH;
                     end else begin
                        state_in      = ST_SCAN;
                     end
                  end
                  ptre_pkg::OP_CLEAR: begin
                     decided_in    = 1'b0;
                     pend_valid_in = 1'b1;
                     pend_kind_in  = ptre_pkg::KIND_ACCEPTED;
                     state_in      = ST_FLUSH;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // own address or stale path: drop
         ST_CHECK: begin
            if (cmp_res.eq || !req_ff.path_fresh) begin
               pend_valid_in = 1'b1;
               pend_kind_in  = ptre_pkg::KIND_IGNORED;
               state_in      = ST_FLUSH;
            end else begin
               state_in      = ST_SCAN;
            end
         end

         // one entry per cycle unless a parked expiry waits for the output register
         ST_SCAN: begin
            if (!scan_stall) begin
               case (req_ff.opcode)
                  ptre_pkg::OP_ANNOUNCE: begin
                     if (ent_vld && cmp_res.eq && !hit_found_ff) begin
                        hit_found_in = 1'b1;
                        hit_idx_in   = idx_ff;
                     end
                     if (!ent_vld && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = idx_ff;
                     end
                  end
                  ptre_pkg::OP_DECIDE: begin
                     if (ent_vld && rd_entry.willing) begin
                        cnt_in = cnt_ff + 1'b1;
                        if (cmp_res.lt) begin
                           root_in = rd_entry.addr;
                        end
                     end
                  end
                  ptre_pkg::OP_TICK: begin
                     if (expire) begin
                        valid_in[idx_ff] = 1'b0;
                        if (room) begin
                           // previous expiry is not the last one: send it
                           if (pend_valid_ff) begin
                              rsp_valid_in              = 1'b1;
                              rsp_data_in.kind          = pend_kind_ff;
                              rsp_data_in.mac_out       = pend_mac_ff;
                              rsp_data_in.is_root_out   = is_root_ff;
                              rsp_data_in.willing_count = pend_cnt_ff;
                              rsp_data_in.last          = 1'b0;
                           end
                           pend_valid_in = 1'b1;
                           pend_kind_in  = ptre_pkg::KIND_EXPIRED;
                           pend_mac_in   = rd_entry.addr;
                           pend_cnt_in   = '0;
                           nres_in       = nres_ff + 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
               idx_in = idx_ff + 1'b1;
               if (last_idx) begin
                  case (req_ff.opcode)
                     ptre_pkg::OP_ANNOUNCE: state_in = ST_WRITE;
                     ptre_pkg::OP_DECIDE:   state_in = ST_DECIDE;
                     default:               state_in = ST_FLUSH;
                  endcase
               end
            end
         end

         // refresh the hit or fill the first free slot; ignore if the table is full
         ST_WRITE: begin
            pend_valid_in = 1'b1;
            if (slot_ok) begin
               valid_in[slot_idx] = 1'b1;
               pend_kind_in       = ptre_pkg::KIND_ACCEPTED;
            end else begin
               pend_kind_in       = ptre_pkg::KIND_IGNORED;
            end
            state_in = ST_FLUSH;
         end

         // fold in own address when volunteering
         ST_DECIDE: begin
            decided_in    = 1'b1;
            pend_valid_in = 1'b1;
            pend_kind_in  = ptre_pkg::KIND_DECIDED;
            pend_cnt_in   = cnt_ff;
            pend_mac_in   = root_ff;
            if (cfg.want_root && (cmp_res.lt || cmp_res.eq)) begin
               pend_mac_in = cfg.own_mac;
               is_root_in  = 1'b1;
            end
            state_in = ST_FLUSH;
         end

         // final result of the item
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.kind          = pend_valid_ff ? pend_kind_ff
                                                         : ptre_pkg::KIND_TICK_NONE;
               rsp_data_in.mac_out       = pend_valid_ff ? pend_mac_ff : '0;
               rsp_data_in.willing_count = pend_valid_ff ? pend_cnt_ff : '0;
               rsp_data_in.is_root_out   = is_root_ff;
               rsp_data_in.last          = 1'b1;
               pend_valid_in             = 1'b0;
               state_in                  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         decided_ff    <= 1'b0;
         is_root_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         decided_ff    <= decided_in;
         is_root_ff    <= is_root_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
   end

   // working data registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      root_ff      <= root_in;
      cnt_ff       <= cnt_in;
      nres_ff      <= nres_in;
      pend_kind_ff <= pend_kind_in;
      pend_mac_ff  <= pend_mac_in;
      pend_cnt_ff  <= pend_cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/portal_table_root_election.sv]
// ============================================================================
// portal_table_root_election - aging portal table with root election
// Stores up to 32 portal announcements, ages them on tick items and elects
// the smallest root-willing address on a decide item.
// ============================================================================
// Each item is handled on its own: req_stall is high from the cycle after an
// item is accepted until its last result has been loaded into the output
// register. Every tick, every decide that is not a repeat and every announce
// that is not rejected walks the whole table through one registered memory
// read port and one shared 48-bit comparator, one entry per cycle unless
// expired entries back up behind a stalled output. Tick results come out one
// per expired entry, in table order, with last set on the final one; a tick
// that expires nothing gives a single "none expired" result. Configuration
// must be written only while no item is in flight; the block itself does not
// enforce this. There is no clearing pass after reset.
// ============================================================================
`default_nettype none

module portal_table_root_election (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  ptre_pkg::req_type                      req_data,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output ptre_pkg::rsp_type                      rsp_data,
   // configuration write port
   input  wire logic                              csr_wr_en,
   input  wire logic [ptre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ptre_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ptre_pkg::cfg_type                 cfg_ff;
   ptre_pkg::tbl_ctl_type             tbl_ctl;
   ptre_pkg::entry_type               wr_entry;
   ptre_pkg::entry_type               rd_entry;
   logic [ptre_pkg::MAC_W-1:0]        cmp_a;
   logic [ptre_pkg::MAC_W-1:0]        cmp_b;
   ptre_pkg::cmp_res_type             cmp_res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac   <= '0;
         cfg_ff.want_root <= 1'b0;
         cfg_ff.timeout   <= ptre_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ptre_pkg::CSR_OWN_MAC:   cfg_ff.own_mac   <= csr_wdata[ptre_pkg::MAC_W-1:0];
            ptre_pkg::CSR_WANT_ROOT: cfg_ff.want_root <= csr_wdata[0];
            ptre_pkg::CSR_TIMEOUT:   cfg_ff.timeout   <= csr_wdata[ptre_pkg::TMR_W-1:0];
            default: ;
         endcase
      end
   end

   ptre_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .tbl_ctl   (tbl_ctl),
      .wr_entry  (wr_entry),
      .rd_entry  (rd_entry),
      .cmp_a     (cmp_a),
      .cmp_b     (cmp_b),
      .cmp_res   (cmp_res)
   );

   ptre_table u_table (
      .clock    (clock),
      .tbl_ctl  (tbl_ctl),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry)
   );

   ptre_cmp u_cmp (
      .cmp_a   (cmp_a),
      .cmp_b   (cmp_b),
      .cmp_res (cmp_res)
   );

endmodule

`default_nettype wire

[rtl/ptre_checker.sv]
// ============================================================================
// ptre_checker - port-level checks for the portal table root election
// Watches only the top-level ports; attached to the top level by bind.
// ============================================================================
`default_nettype none

module ptre_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  ptre_pkg::rsp_type                      rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time: the block is busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an item was accepted");

   // only a decision carries a willing count
   a_count_only_decided: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != ptre_pkg::KIND_DECIDED) |->
         (rsp_data.willing_count == '0))
      else $error("willing count on a non-decision result");

   // once root, every later result says so
   a_root_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.is_root_out |=>
         !rsp_valid || rsp_data.is_root_out)
      else $error("root flag dropped");

endmodule

bind portal_table_root_election ptre_checker u_ptre_checker (.*);

`default_nettype wire
